FILE: rtl/hs2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hs2d_pkg: shared types and constants
// Payload structs, queue entry type and defaults for the hex string to
// decimal digit converter.
// ----------------------------------------------------------------------------
package hs2d_pkg;

  localparam int ACC_W         = 32;  // accumulated binary value
  localparam int NIB_W         = 4;
  localparam int HEX_CNT_W     = 4;   // saturating digit count
  localparam int CHAR_W        = 8;
  localparam int DIGITS_W      = 39;  // packed BCD output field
  localparam int DCOUNT_W      = 4;
  localparam int STEP_W        = $clog2(ACC_W);

  localparam int MAX_HEX_DIGITS_DEF = 8;
  localparam int DEC_DIGITS_DEF     = 10;

  localparam int QUEUE_DEPTH = 2;     // power of two
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UP_F = 8'h46;
  localparam logic [CHAR_W-1:0] ASCII_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LO_F = 8'h66;
  localparam logic [NIB_W-1:0]  NIB_TEN    = 4'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] hex_char;
    logic              last;
  } char_t;

  typedef struct packed {
    logic [DIGITS_W-1:0] decimal_digits;
    logic [DCOUNT_W-1:0] digit_count;
    logic                bad_char;
    logic                too_long;
  } result_t;

  // One finished number waiting for conversion
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             bad;
    logic             long_flag;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_port_t;

endpackage : hs2d_pkg
`default_nettype wire

FILE: rtl/hs2d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hs2d_front: character intake
// Decodes ASCII hex characters, accumulates the value and flags, and pushes
// a finished number into the job queue on the last character.
// ----------------------------------------------------------------------------
module hs2d_front #(
  parameter int MAX_HEX_DIGITS = hs2d_pkg::MAX_HEX_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire hs2d_pkg::char_t   char_data,
  input  wire logic              q_full,
  output hs2d_pkg::job_port_t    push
);
  import hs2d_pkg::*;

  localparam logic [HEX_CNT_W:0] MAX_CNT = (HEX_CNT_W+1)'(MAX_HEX_DIGITS);

  logic [ACC_W-1:0]     accum_value, accum_value_next;
  logic [HEX_CNT_W-1:0] hex_count, hex_count_next;
  logic                 bad_seen, bad_seen_next;
  logic                 long_seen, long_seen_next;
  logic [NIB_W-1:0]     nib;
  logic                 is_hex;
  logic                 take;
  logic                 accept;

  assign char_stall = q_full;
  assign accept     = char_valid && !char_stall;

  always_comb begin
    is_hex = 1'b1;
    nib    = '0;
    if (char_data.hex_char >= ASCII_ZERO && char_data.hex_char <= ASCII_NINE) begin
      nib = NIB_W'(char_data.hex_char - ASCII_ZERO);
    end else if (char_data.hex_char >= ASCII_UP_A && char_data.hex_char <= ASCII_UP_F) begin
      nib = NIB_TEN + NIB_W'(char_data.hex_char - ASCII_UP_A);
    end else if (char_data.hex_char >= ASCII_LO_A && char_data.hex_char <= ASCII_LO_F) begin
      nib = NIB_TEN + NIB_W'(char_data.hex_char - ASCII_LO_A);
    end else begin
      is_hex = 1'b0;  // counts as a zero digit
    end
  end

  always_comb begin
    take             = {1'b0, hex_count} < MAX_CNT;
    accum_value_next = take ? {accum_value[ACC_W-NIB_W-1:0], nib} : accum_value;
    hex_count_next   = (take && hex_count != '1) ? hex_count + 1'b1 : hex_count;
    bad_seen_next    = bad_seen | ~is_hex;
    long_seen_next   = long_seen | ~take;
  end

  always_comb begin
    push.valid         = accept && char_data.last;
    push.job.value     = accum_value_next;
    push.job.bad       = bad_seen_next;
    push.job.long_flag = long_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_value <= '0;
      hex_count   <= '0;
      bad_seen    <= 1'b0;
      long_seen   <= 1'b0;
    end else if (accept) begin
      if (char_data.last) begin
        accum_value <= '0;
        hex_count   <= '0;
        bad_seen    <= 1'b0;
        long_seen   <= 1'b0;
      end else begin
        accum_value <= accum_value_next;
        hex_count   <= hex_count_next;
        bad_seen    <= bad_seen_next;
        long_seen   <= long_seen_next;
      end
    end
  end

endmodule : hs2d_front
`default_nettype wire

FILE: rtl/hs2d_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hs2d_queue: job queue
// Short register FIFO between the character front end and the converter.
// ----------------------------------------------------------------------------
module hs2d_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hs2d_pkg::job_port_t push,
  output logic                     full,
  output hs2d_pkg::job_port_t      head,
  input  wire logic                pop
);
  import hs2d_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      if (push.valid && !pop)      count <= count + 1'b1;
      else if (pop && !push.valid) count <= count - 1'b1;
    end
  end

endmodule : hs2d_queue
`default_nettype wire

FILE: rtl/hs2d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hs2d_back: binary to BCD converter
// Shift-and-add-3 conversion, one bit per cycle, then digit count and a
// registered result stage.
// ----------------------------------------------------------------------------
module hs2d_back #(
  parameter int DEC_DIGITS = hs2d_pkg::DEC_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hs2d_pkg::job_port_t head,
  output logic                     pop,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output hs2d_pkg::result_t        res_data
);
  import hs2d_pkg::*;

  localparam int BCD_W   = 4 * DEC_DIGITS;
  localparam int SCAN_W  = 5;  // holds digit positions up to 31
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ACC_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic              bad;
  logic              long_flag;
  logic              load_out;
  logic [SCAN_W-1:0] sig_cnt;
  logic [BCD_W+DIGITS_W-1:0] bcd_wide;

  assign pop      = (state == ST_IDLE) && head.valid;
  assign load_out = (state == ST_DONE) && (!res_valid || !res_stall);
  assign bcd_wide = {{DIGITS_W{1'b0}}, bcd};

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // highest nonzero digit; zero reads as one digit
  always_comb begin
    sig_cnt = SCAN_W'(1);
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) sig_cnt = SCAN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) state <= ST_CONV;
        end
        ST_CONV: begin
          step <= step + 1'b1;
          if (step == STEP_LAST) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bin       <= head.job.value;
      bcd       <= '0;
      bad       <= head.job.bad;
      long_flag <= head.job.long_flag;
    end else if (state == ST_CONV) begin
      bin <= {bin[ACC_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[ACC_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_data.decimal_digits <= bcd_wide[DIGITS_W-1:0];
      res_data.digit_count    <= sig_cnt[DCOUNT_W-1:0];
      res_data.bad_char       <= bad;
      res_data.too_long       <= long_flag;
    end
  end

`ifndef SYNTHESIS
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_CONV |-> step == '0)
    else $error("bit counter running outside conversion");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_CONV)
    else $error("job popped without starting conversion");

  a_bin_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> bin == '0)
    else $error("conversion finished with bits left");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> res_valid && state == ST_IDLE)
    else $error("result load did not complete");
`endif

endmodule : hs2d_back
`default_nettype wire

FILE: rtl/hex_string_to_decimal_digits.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_string_to_decimal_digits: hex character stream to packed BCD
// Accumulates a 32-bit value from ASCII hex characters and converts it to
// decimal digits with a significant-digit count and error flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  char    | in  | char_valid/char_stall | char_data (hex_char, last)
//  res     | out | res_valid/res_stall   | res_data (digits, count, flags)
//
//  The front end takes one character transfer per cycle while char_stall is low.
//  Each number passes through the converter as queue pop, 32 shift-add-3
//  steps (one input bit per cycle), result load.
//  A two-entry job queue sits between them; char_stall rises when it is full.
//  Reset (rst, synchronous) clears the accumulator, queue and converter.
//  A stalled result is held in its output register while conversion of the
//  next queued number proceeds up to its load step.
// ----------------------------------------------------------------------------
module hex_string_to_decimal_digits #(
  parameter int MAX_HEX_DIGITS = hs2d_pkg::MAX_HEX_DIGITS_DEF,
  parameter int DEC_DIGITS     = hs2d_pkg::DEC_DIGITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire hs2d_pkg::char_t   char_data,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output hs2d_pkg::result_t      res_data
);
  import hs2d_pkg::*;

  job_port_t push;   // finished number from the front end
  job_port_t head;   // oldest queued number
  logic      q_full;
  logic      pop;

  // Character decode and accumulation
  hs2d_front #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .q_full     (q_full),
    .push       (push)
  );

  // Decouples intake from the multi-cycle conversion
  hs2d_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // Binary to BCD conversion and result register
  hs2d_back #(
    .DEC_DIGITS (DEC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule : hex_string_to_decimal_digits
`default_nettype wire

FILE: test/hex_string_to_decimal_digits_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_string_to_decimal_digits_tb: self-checking bench for the hex to BCD block
// Streams hex numbers as ASCII characters, some with bad characters and some
// too long. A scoreboard predicts the BCD digits, digit count and error flags
// for every number, and checks them against each result transfer under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module hex_string_to_decimal_digits_tb;
  import hs2d_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 600000;  // slowest run needs well under this
  localparam int SEGMENT_LEN  = 230;     // minimum characters per idle/stall phase
  localparam int NUM_SEGMENTS = 8;
  localparam int SETTLE_CYC   = 100;     // covers one conversion per queue entry

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the accumulator and flags, queues one expected
  // result per number, and checks result transfers in order.
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    logic [ACC_W-1:0]     acc_value;
    logic [HEX_CNT_W-1:0] digits_taken;
    logic                 saw_bad;
    logic                 saw_long;
    result_t              expected_results[$];
    int                   n_errors;
    int                   n_checked;
    int                   n_bad;
    int                   n_long;

    function new();
      clear_number();
      n_errors  = 0;
      n_checked = 0;
      n_bad     = 0;
      n_long    = 0;
    endfunction

    function void clear_number();
      acc_value    = '0;
      digits_taken = '0;
      saw_bad      = 1'b0;
      saw_long     = 1'b0;
    endfunction

    // Called on every accepted character transfer.
    function void note_char(char_t c);
      logic [NIB_W-1:0] nib;
      logic [ACC_W-1:0] rest;
      logic [63:0]      bcd;
      logic [3:0]       dig;
      int               n_sig;
      result_t          r;
      if (c.hex_char >= ASCII_ZERO && c.hex_char <= ASCII_NINE) begin
        nib = NIB_W'(c.hex_char - ASCII_ZERO);
      end else if (c.hex_char >= ASCII_UP_A && c.hex_char <= ASCII_UP_F) begin
        nib = NIB_W'(c.hex_char - ASCII_UP_A) + NIB_TEN;
      end else if (c.hex_char >= ASCII_LO_A && c.hex_char <= ASCII_LO_F) begin
        nib = NIB_W'(c.hex_char - ASCII_LO_A) + NIB_TEN;
      end else begin
        nib     = '0;  // non-hex: zero digit, flagged
        saw_bad = 1'b1;
      end
      if (int'(digits_taken) < MAX_HEX_DIGITS_DEF) begin
        acc_value = {acc_value[ACC_W-NIB_W-1:0], nib};
        if (digits_taken != '1) digits_taken = digits_taken + 1'b1;
      end else begin
        saw_long = 1'b1;  // digit dropped
      end
      if (!c.last) return;

      rest  = acc_value;
      bcd   = '0;
      n_sig = 0;
      for (int k = 0; k < DEC_DIGITS_DEF; k++) begin
        dig = 4'(rest % 10);
        if (k < 16) bcd[4*k +: 4] = dig;
        rest = rest / 10;
        if (dig != 0) n_sig = k + 1;
      end
      if (n_sig == 0) n_sig = 1;
      r.decimal_digits = bcd[DIGITS_W-1:0];
      r.digit_count    = DCOUNT_W'(n_sig);
      r.bad_char       = saw_bad;
      r.too_long       = saw_long;
      expected_results.push_back(r);
      if (saw_bad) n_bad++;
      if (saw_long) n_long++;
      clear_number();
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      bit      wrong;
      if (expected_results.size() == 0) begin
        $error("result transfer with no number pending: digits %h", got.decimal_digits);
        n_errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      wrong = 1'b0;
      n_checked++;
      if (got.decimal_digits !== exp_r.decimal_digits) begin
        $error("decimal_digits: expected %h, actual %h",
               exp_r.decimal_digits, got.decimal_digits);
        wrong = 1'b1;
      end
      if (got.digit_count !== exp_r.digit_count) begin
        $error("digit_count: expected %0d, actual %0d", exp_r.digit_count, got.digit_count);
        wrong = 1'b1;
      end
      if (got.bad_char !== exp_r.bad_char) begin
        $error("bad_char: expected %b, actual %b", exp_r.bad_char, got.bad_char);
        wrong = 1'b1;
      end
      if (got.too_long !== exp_r.too_long) begin
        $error("too_long: expected %b, actual %b", exp_r.too_long, got.too_long);
        wrong = 1'b1;
      end
      if (wrong) n_errors++;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic    clk;
  logic    rst;
  logic    char_valid;
  logic    char_stall;
  char_t   char_data;
  logic    res_valid;
  logic    res_stall;
  result_t res_data;

  digit_scoreboard board;
  int idle_pct;    // percent chance per draw that the sender idles before a transfer
  int stall_pct;   // chance per cycle that the receiver stalls
  int n_chars;
  int n_numbers;
  int cycles;

  hex_string_to_decimal_digits dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_data (char_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hex_string_to_decimal_digits_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stall decided at the falling edge, stable at the rising one
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result transfer -> scoreboard
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_result(res_data);
  end

  // --------------------------------------------------------------------------
  // Sender tasks; called at a falling edge and return at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
    char_t c;
    c.hex_char = ch;
    c.last     = is_last;
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_data  <= c;
    char_valid <= 1'b1;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    board.note_char(c);  // transfer done at this edge
    n_chars++;
    if (is_last) n_numbers++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Pause the sender until every pending result has been taken.
  task automatic drain();
    char_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] rand_hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return ASCII_ZERO + CHAR_W'(d);
    return ($urandom_range(1) ? ASCII_UP_A : ASCII_LO_A) + CHAR_W'(d - 10);
  endfunction

  // One random number: mostly clean and eight digits or fewer; some too long,
  // some with junk bytes mixed in.
  task automatic send_random_number();
    int sel;
    int len;
    bit noisy;
    logic [CHAR_W-1:0] ch;
    sel = $urandom_range(99);
    if (sel < 30)      len = MAX_HEX_DIGITS_DEF;
    else if (sel < 80) len = $urandom_range(MAX_HEX_DIGITS_DEF - 1, 1);
    else               len = $urandom_range(20, MAX_HEX_DIGITS_DEF + 1);
    noisy = ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(99) < 30) ch = CHAR_W'($urandom_range(255));
      else                                  ch = rand_hex_char();
      send_char(ch, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    int seg_start;
    idle_tbl  = '{0, 59, 0, 35};
    stall_tbl = '{0, 0, 59, 35};
    board      = new();
    cycles     = 0;
    n_chars    = 0;
    n_numbers  = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_data  = '0;
    res_stall  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero, max value in lower case, single letter, lone bad char,
    // too many digits in mixed case, bad byte followed by a digit.
    send_text("0");
    send_text("ffffffff");
    send_text("A");
    send_text("G");
    send_text("1aB2cD3e4");
    send_char(8'hFF, 1'b0);
    send_text("F");
    drain();

    // Random segments cycling through the idle/stall phases; each segment
    // starts from an empty pipeline.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      idle_pct  = idle_tbl[seg % 4];
      stall_pct = stall_tbl[seg % 4];
      seg_start = n_chars;
      while (n_chars - seg_start < SEGMENT_LEN) send_random_number();
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    char_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Sent %0d characters in %0d numbers; checked %0d results.",
             n_chars, n_numbers, board.n_checked);
    $display("Numbers with bad characters: %0d, too long: %0d.", board.n_bad, board.n_long);
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("hex_string_to_decimal_digits_tb: PASS");
    end else begin
      $display("hex_string_to_decimal_digits_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hs2d_pkg.sv
rtl/hs2d_front.sv
rtl/hs2d_queue.sv
rtl/hs2d_back.sv
rtl/hex_string_to_decimal_digits.sv
test/hex_string_to_decimal_digits_tb.sv
